// ===== rtl/framebuffer_draw_engine_unit_defines.svh =====
// assertion macros for the draw engine unit
`ifndef FRAMEBUFFER_DRAW_ENGINE_UNIT_DEFINES_SVH
`define FRAMEBUFFER_DRAW_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FBDE_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("draw engine check failed");

// next-cycle implication, checked out of reset
`define FBDE_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("draw engine check failed");

`endif

// ===== rtl/fbde_pkg.sv =====
package fbde_pkg;

  // signed coordinate width, wide enough for origin plus size plus offsets
  localparam int CW = 16;
  typedef logic signed [CW-1:0] coord_t;

  // configuration register indexes
  localparam logic REG_SCROLL_X = 1'b0;
  localparam logic REG_SCROLL_Y = 1'b1;

  // command codes
  typedef enum logic [2:0] {
    OP_CLEAR   = 3'd0,
    OP_POINT   = 3'd1,
    OP_BLIT    = 3'd2,
    OP_OUTLINE = 3'd3,
    OP_FILL    = 3'd4,
    OP_READ    = 3'd5
  } op_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ORIGIN,
    ST_SETUP,
    ST_FILL,
    ST_OUT_H,
    ST_OUT_V,
    ST_PIXEL,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/framebuffer_draw_engine_unit.sv =====
// channel   | signals                                              | handshake
// ----------+------------------------------------------------------+--------------------------
// command   | operation pos_x pos_y size_w size_h sub_x sub_y      | start high, busy low
//           | color fixed                                          |
// config    | cfg_index cfg_data                                   | cfg_write high
// result    | read_data clipped                                    | done high for one cycle
//
// point, blit and read: origin, setup and pixel states, then done
// fill: origin, setup, a raster walk over the clipped area unless it is empty, then done;
// clear: the same walk over the whole screen; outline: origin, setup, top and bottom edges,
// left and right edges, then done; walks write one pixel per cycle on the single write port
// reset clears the sequencer and scroll registers; frame store holds garbage until drawn
// the result strobe cannot be held off; busy stays high until the cycle after done
`include "framebuffer_draw_engine_unit_defines.svh"

module framebuffer_draw_engine_unit #(
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 256,
  parameter int SOURCE_SIDE   = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         operation,
  input  logic signed [12:0] pos_x,
  input  logic signed [12:0] pos_y,
  input  logic [12:0]        size_w,
  input  logic [12:0]        size_h,
  input  logic [7:0]         sub_x,
  input  logic [7:0]         sub_y,
  input  logic [23:0]        color,
  input  logic               fixed,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [12:0]        cfg_data,
  output logic               done,
  output logic [23:0]        read_data,
  output logic               clipped
);

  localparam int DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int XW     = $clog2(SCREEN_WIDTH);
  localparam int YW     = $clog2(SCREEN_HEIGHT);
  localparam logic [ADDR_W-1:0] WIDTH_A = ADDR_W'(SCREEN_WIDTH);
  localparam fbde_pkg::coord_t SCR_W = fbde_pkg::coord_t'(SCREEN_WIDTH);
  localparam fbde_pkg::coord_t SCR_H = fbde_pkg::coord_t'(SCREEN_HEIGHT);
  localparam logic [8:0] SRC_SIDE = 9'(SOURCE_SIDE);
  localparam int PAD = fbde_pkg::CW - 13;

  fbde_pkg::state_t state, state_next;

  // latched request
  fbde_pkg::op_t     op_q;
  logic signed [12:0] px_q, py_q;
  logic [12:0]        w_q, h_q;
  logic [7:0]         sx_q, sy_q;
  logic [23:0]        color_q;
  logic               fixed_q;

  // scroll registers
  logic signed [12:0] scroll_x, scroll_y;

  // walker registers
  fbde_pkg::coord_t org_x, org_x_next, org_y, org_y_next;
  fbde_pkg::coord_t cur_x, cur_x_next, cur_y, cur_y_next;
  fbde_pkg::coord_t x_lo, x_lo_next, x_end, x_end_next, y_end, y_end_next;
  logic             phase, phase_next;
  logic             clip_flag, clip_flag_next;
  logic             is_read, is_read_next;

  // frame store
  logic [23:0] frame_store [DEPTH];
  logic [23:0] mem_q;
  logic [ADDR_W-1:0] addr;
  logic wr_en, rd_en;

  // combinational helpers
  fbde_pkg::coord_t pix_x, pix_y;
  fbde_pkg::coord_t sum_x, sum_y, lo_x, lo_y, hi_x, hi_y, inc_x, inc_y;
  logic on_scr, src_bad, use_scroll, accept;

  assign accept  = start && !busy;
  assign src_bad = ({1'b0, sx_q} >= SRC_SIDE) || ({1'b0, sy_q} >= SRC_SIDE);

  // request and scroll registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_x <= '0;
      scroll_y <= '0;
    end else if (cfg_write) begin
      if (cfg_index == fbde_pkg::REG_SCROLL_X) begin
        scroll_x <= cfg_data;
      end else begin
        scroll_y <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= fbde_pkg::op_t'(operation);
      px_q    <= pos_x;
      py_q    <= pos_y;
      w_q     <= size_w;
      h_q     <= size_h;
      sx_q    <= sub_x;
      sy_q    <= sub_y;
      color_q <= color;
      fixed_q <= fixed;
    end
  end

  // sequencer and walker registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fbde_pkg::ST_IDLE;
      clip_flag <= 1'b0;
      is_read   <= 1'b0;
      phase     <= 1'b0;
    end else begin
      state     <= state_next;
      clip_flag <= clip_flag_next;
      is_read   <= is_read_next;
      phase     <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    org_x <= org_x_next;
    org_y <= org_y_next;
    cur_x <= cur_x_next;
    cur_y <= cur_y_next;
    x_lo  <= x_lo_next;
    x_end <= x_end_next;
    y_end <= y_end_next;
  end

  // pixel coordinate driven onto the store this cycle
  always_comb begin
    pix_x = cur_x;
    pix_y = cur_y;
    case (state)
      fbde_pkg::ST_OUT_H: pix_y = phase ? y_end : org_y;
      fbde_pkg::ST_OUT_V: pix_x = phase ? x_end : org_x;
      default: ;
    endcase
  end

  assign on_scr = (pix_x >= 0) && (pix_x < SCR_W) && (pix_y >= 0) && (pix_y < SCR_H);
  assign addr   = ADDR_W'(pix_x[XW-1:0]) + ADDR_W'(pix_y[YW-1:0]) * WIDTH_A;

  // shared adder outputs for setup and stepping
  assign sum_x = org_x + fbde_pkg::coord_t'({{PAD{1'b0}}, w_q});
  assign sum_y = org_y + fbde_pkg::coord_t'({{PAD{1'b0}}, h_q});
  assign lo_x  = (org_x < 0) ? '0 : org_x;
  assign lo_y  = (org_y < 0) ? '0 : org_y;
  assign hi_x  = (sum_x > SCR_W) ? SCR_W : sum_x;
  assign hi_y  = (sum_y > SCR_H) ? SCR_H : sum_y;
  assign inc_x = cur_x + fbde_pkg::coord_t'(1);
  assign inc_y = cur_y + fbde_pkg::coord_t'(1);
  assign use_scroll = fixed_q && ((op_q == fbde_pkg::OP_BLIT) ||
                                  (op_q == fbde_pkg::OP_OUTLINE) ||
                                  (op_q == fbde_pkg::OP_FILL));

  // next state and walker updates
  always_comb begin
    state_next     = state;
    org_x_next     = org_x;
    org_y_next     = org_y;
    cur_x_next     = cur_x;
    cur_y_next     = cur_y;
    x_lo_next      = x_lo;
    x_end_next     = x_end;
    y_end_next     = y_end;
    phase_next     = phase;
    clip_flag_next = clip_flag;
    is_read_next   = is_read;
    case (state)
      fbde_pkg::ST_IDLE: begin
        if (accept) begin
          state_next     = fbde_pkg::ST_ORIGIN;
          clip_flag_next = 1'b0;
          is_read_next   = 1'b0;
          phase_next     = 1'b0;
        end
      end
      // origin with optional camera offset
      fbde_pkg::ST_ORIGIN: begin
        org_x_next = fbde_pkg::coord_t'(px_q) -
                     (use_scroll ? fbde_pkg::coord_t'(scroll_x) : '0);
        org_y_next = fbde_pkg::coord_t'(py_q) -
                     (use_scroll ? fbde_pkg::coord_t'(scroll_y) : '0);
        state_next = fbde_pkg::ST_SETUP;
      end
      // per-command bounds
      fbde_pkg::ST_SETUP: begin
        case (op_q)
          fbde_pkg::OP_CLEAR: begin
            x_lo_next  = '0;
            cur_x_next = '0;
            cur_y_next = '0;
            x_end_next = SCR_W;
            y_end_next = SCR_H;
            state_next = fbde_pkg::ST_FILL;
          end
          fbde_pkg::OP_FILL: begin
            x_lo_next  = lo_x;
            cur_x_next = lo_x;
            cur_y_next = lo_y;
            x_end_next = hi_x;
            y_end_next = hi_y;
            if ((lo_x >= hi_x) || (lo_y >= hi_y)) begin
              state_next = fbde_pkg::ST_DONE;
            end else begin
              state_next = fbde_pkg::ST_FILL;
            end
          end
          fbde_pkg::OP_POINT, fbde_pkg::OP_READ: begin
            cur_x_next = org_x;
            cur_y_next = org_y;
            state_next = fbde_pkg::ST_PIXEL;
          end
          fbde_pkg::OP_BLIT: begin
            cur_x_next = org_x + fbde_pkg::coord_t'({{(fbde_pkg::CW-8){1'b0}}, sx_q});
            cur_y_next = org_y + fbde_pkg::coord_t'({{(fbde_pkg::CW-8){1'b0}}, sy_q});
            state_next = fbde_pkg::ST_PIXEL;
          end
          fbde_pkg::OP_OUTLINE: begin
            cur_x_next = org_x;
            cur_y_next = org_y;
            x_end_next = sum_x;
            y_end_next = sum_y;
            state_next = (w_q == '0) ? fbde_pkg::ST_OUT_V : fbde_pkg::ST_OUT_H;
          end
          default: state_next = fbde_pkg::ST_DONE;
        endcase
      end
      // raster walk over the clamped rectangle
      fbde_pkg::ST_FILL: begin
        if (inc_x == x_end) begin
          cur_x_next = x_lo;
          cur_y_next = inc_y;
          if (inc_y == y_end) begin
            state_next = fbde_pkg::ST_DONE;
          end
        end else begin
          cur_x_next = inc_x;
        end
      end
      // top and bottom edges, two writes per column
      fbde_pkg::ST_OUT_H: begin
        phase_next = !phase;
        if (phase) begin
          if (inc_x == x_end) begin
            cur_y_next = org_y;
            state_next = fbde_pkg::ST_OUT_V;
          end else begin
            cur_x_next = inc_x;
          end
        end
      end
      // left and right edges, rows inclusive of the bottom one
      fbde_pkg::ST_OUT_V: begin
        phase_next = !phase;
        if (phase) begin
          if (cur_y == y_end) begin
            state_next = fbde_pkg::ST_DONE;
          end else begin
            cur_y_next = inc_y;
          end
        end
      end
      // single pixel commands
      fbde_pkg::ST_PIXEL: begin
        case (op_q)
          fbde_pkg::OP_BLIT: clip_flag_next = src_bad || !on_scr;
          fbde_pkg::OP_READ: begin
            clip_flag_next = !on_scr;
            is_read_next   = on_scr;
          end
          default: clip_flag_next = !on_scr;
        endcase
        state_next = fbde_pkg::ST_DONE;
      end
      fbde_pkg::ST_DONE: state_next = fbde_pkg::ST_IDLE;
      default: state_next = fbde_pkg::ST_IDLE;
    endcase
  end

  // store strobes and result outputs
  always_comb begin
    wr_en = 1'b0;
    rd_en = 1'b0;
    case (state)
      fbde_pkg::ST_FILL, fbde_pkg::ST_OUT_H, fbde_pkg::ST_OUT_V: wr_en = on_scr;
      fbde_pkg::ST_PIXEL: begin
        case (op_q)
          fbde_pkg::OP_POINT: wr_en = on_scr;
          fbde_pkg::OP_BLIT:  wr_en = on_scr && !src_bad;
          fbde_pkg::OP_READ:  rd_en = on_scr;
          default: ;
        endcase
      end
      default: ;
    endcase
    busy      = (state != fbde_pkg::ST_IDLE);
    done      = (state == fbde_pkg::ST_DONE);
    read_data = is_read ? mem_q : '0;
    clipped   = clip_flag;
  end

  // frame store, one access per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_store[addr] <= color_q;
    end
    if (rd_en) begin
      mem_q <= frame_store[addr];
    end
  end

  `FBDE_ASSERT_NOW(a_done_busy, clk, rst, done, busy)
  `FBDE_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy && !done)
  `FBDE_ASSERT_NEXT(a_done_idle, clk, rst, done, !busy)
  `FBDE_ASSERT_NOW(a_one_access, clk, rst, wr_en || rd_en, on_scr && !(wr_en && rd_en))

endmodule

// ===== bench/framebuffer_draw_engine_unit_checker.sv =====
`timescale 1ns / 1ps

module framebuffer_draw_engine_unit_checker #(
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 256,
  parameter int SOURCE_SIDE   = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         operation,
  input  logic signed [12:0] pos_x,
  input  logic signed [12:0] pos_y,
  input  logic [12:0]        size_w,
  input  logic [12:0]        size_h,
  input  logic [7:0]         sub_x,
  input  logic [7:0]         sub_y,
  input  logic [23:0]        color,
  input  logic               fixed,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [12:0]        cfg_data,
  input  logic               done,
  input  logic [23:0]        read_data,
  input  logic               clipped,
  output int unsigned        mismatches,
  output int unsigned        awaiting
);

  localparam int PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;

  typedef struct packed {
    logic [23:0] read_data;
    logic        clipped;
  } pixel_reply_t;

  // shadow copy of the frame and the scroll registers
  logic [23:0]  frame_copy [PIXELS];
  int           scroll_x_now = 0;
  int           scroll_y_now = 0;
  pixel_reply_t awaited_replies [$];
  int unsigned  error_total = 0;

  assign mismatches = error_total;

  function automatic bit on_screen(input int x, input int y);
    return x >= 0 && x < SCREEN_WIDTH && y >= 0 && y < SCREEN_HEIGHT;
  endfunction

  task automatic plot(input int x, input int y, input logic [23:0] c);
    if (on_screen(x, y)) frame_copy[x + y * SCREEN_WIDTH] = c;
  endtask

  // apply the request on the port to the shadow frame, work out its reply
  task automatic render_command(output pixel_reply_t reply);
    int px, py, ox, oy, w, h, sx, sy, xa, xb, ya, yb;
    reply = '0;
    px = pos_x;
    py = pos_y;
    w  = size_w;
    h  = size_h;
    sx = sub_x;
    sy = sub_y;
    ox = px;
    oy = py;
    if (fixed && (operation == fbde_pkg::OP_BLIT || operation == fbde_pkg::OP_OUTLINE ||
                  operation == fbde_pkg::OP_FILL))
    begin
      ox = px - scroll_x_now;
      oy = py - scroll_y_now;
    end
    xa = (ox < 0) ? 0 : ox;
    ya = (oy < 0) ? 0 : oy;
    case (operation)
      fbde_pkg::OP_CLEAR: begin
        foreach (frame_copy[i]) frame_copy[i] = color;
      end
      fbde_pkg::OP_POINT: begin
        if (on_screen(px, py)) plot(px, py, color);
        else reply.clipped = 1'b1;
      end
      fbde_pkg::OP_BLIT: begin
        if (sx >= SOURCE_SIDE || sy >= SOURCE_SIDE || !on_screen(ox + sx, oy + sy))
          reply.clipped = 1'b1;
        else
          plot(ox + sx, oy + sy, color);
      end
      fbde_pkg::OP_OUTLINE: begin
        // horizontal edges stop one short, vertical edges include both ends
        xb = (ox + w < SCREEN_WIDTH) ? ox + w : SCREEN_WIDTH;
        for (int x = xa; x < xb; x++) begin
          plot(x, oy, color);
          plot(x, oy + h, color);
        end
        yb = (oy + h < SCREEN_HEIGHT - 1) ? oy + h : SCREEN_HEIGHT - 1;
        for (int y = ya; y <= yb; y++) begin
          plot(ox, y, color);
          plot(ox + w, y, color);
        end
      end
      fbde_pkg::OP_FILL: begin
        xb = (ox + w < SCREEN_WIDTH) ? ox + w : SCREEN_WIDTH;
        yb = (oy + h < SCREEN_HEIGHT) ? oy + h : SCREEN_HEIGHT;
        for (int y = ya; y < yb; y++)
          for (int x = xa; x < xb; x++)
            frame_copy[x + y * SCREEN_WIDTH] = color;
      end
      fbde_pkg::OP_READ: begin
        if (on_screen(px, py)) reply.read_data = frame_copy[px + py * SCREEN_WIDTH];
        else reply.clipped = 1'b1;
      end
      default: begin
        // spare codes leave the frame alone and answer zero
      end
    endcase
  endtask

  // watch all three channels at each rising edge
  always @(posedge clk) begin
    pixel_reply_t want;
    if (rst) begin
      scroll_x_now = 0;
      scroll_y_now = 0;
      awaited_replies.delete();
    end else begin
      // result: compare with the oldest prediction
      if (done) begin
        if (awaited_replies.size() == 0) begin
          error_total++;
          if (error_total <= 10)
            $display("%0t: unexpected result read_data %h clipped %b",
                     $time, read_data, clipped);
        end else begin
          want = awaited_replies.pop_front();
          if (read_data !== want.read_data || clipped !== want.clipped) begin
            error_total++;
            if (error_total <= 10)
              $display("%0t: mismatch read_data exp %h got %h, clipped exp %b got %b",
                       $time, want.read_data, read_data, want.clipped, clipped);
          end
        end
      end
      // register writes
      if (cfg_write) begin
        if (cfg_index == fbde_pkg::REG_SCROLL_X) scroll_x_now = signed'(cfg_data);
        else scroll_y_now = signed'(cfg_data);
      end
      // accepted request
      if (start && !busy) begin
        render_command(want);
        awaited_replies.push_back(want);
      end
    end
    awaiting = awaited_replies.size();
  end

endmodule

// ===== bench/framebuffer_draw_engine_unit_tb.sv =====
`timescale 1ns / 1ps

module framebuffer_draw_engine_unit_tb;

  localparam int          RANDOM_PER_PHASE = 410;
  localparam int unsigned CYCLE_LIMIT      = 4_000_000;

  // codes the block treats as no-ops
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef struct {
    logic [2:0]         opc;
    logic signed [12:0] px;
    logic signed [12:0] py;
    logic [12:0]        w;
    logic [12:0]        h;
    logic [7:0]         sx;
    logic [7:0]         sy;
    logic [23:0]        c;
    logic               fx;
  } draw_cmd_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic [2:0]         operation;
  logic signed [12:0] pos_x;
  logic signed [12:0] pos_y;
  logic [12:0]        size_w;
  logic [12:0]        size_h;
  logic [7:0]         sub_x;
  logic [7:0]         sub_y;
  logic [23:0]        color;
  logic               fixed;
  logic               cfg_write;
  logic               cfg_index;
  logic [12:0]        cfg_data;
  logic               done;
  logic [23:0]        read_data;
  logic               clipped;
  int unsigned        mismatches;
  int unsigned        awaiting;

  int unsigned        cycle_count = 0;
  int                 scroll_x_set = 0;
  int                 scroll_y_set = 0;
  logic signed [12:0] last_x = '0;
  logic signed [12:0] last_y = '0;
  draw_cmd_t          directed [$];

  always #10 clk = ~clk;

  framebuffer_draw_engine_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .pos_x(pos_x), .pos_y(pos_y),
    .size_w(size_w), .size_h(size_h), .sub_x(sub_x), .sub_y(sub_y),
    .color(color), .fixed(fixed),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .read_data(read_data), .clipped(clipped)
  );

  framebuffer_draw_engine_unit_checker pixel_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .pos_x(pos_x), .pos_y(pos_y),
    .size_w(size_w), .size_h(size_h), .sub_x(sub_x), .sub_y(sub_y),
    .color(color), .fixed(fixed),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .read_data(read_data), .clipped(clipped),
    .mismatches(mismatches), .awaiting(awaiting)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL framebuffer_draw_engine_unit");
      $finish;
    end
  end

  function automatic draw_cmd_t make_cmd(input logic [2:0] opc, input int px, input int py,
                                         input int w, input int h, input int sx, input int sy,
                                         input logic [23:0] c, input logic fx);
    draw_cmd_t cmd;
    cmd.opc = opc;
    cmd.px  = 13'(px);
    cmd.py  = 13'(py);
    cmd.w   = 13'(w);
    cmd.h   = 13'(h);
    cmd.sx  = 8'(sx);
    cmd.sy  = 8'(sy);
    cmd.c   = c;
    cmd.fx  = fx;
    return cmd;
  endfunction

  // mostly small rectangles, now and then up to 4096
  function automatic logic [12:0] random_extent();
    int unsigned r;
    r = $urandom_range(999);
    if (r < 940) return 13'($urandom_range(15));
    if (r < 990) return 13'($urandom_range(80));
    return 13'($urandom_range(4096));
  endfunction

  // mostly near the visible window, otherwise anywhere in the field
  function automatic logic signed [12:0] random_coord(input int aim);
    if ($urandom_range(99) < 80) return 13'(aim + int'($urandom_range(287)) - 16);
    return 13'($urandom_range(8191));
  endfunction

  task automatic random_command(output draw_cmd_t cmd);
    int unsigned pick;
    int          aim_x, aim_y;
    pick = $urandom_range(999);
    if (pick < 2) cmd.opc = fbde_pkg::OP_CLEAR;
    else if (pick < 232) cmd.opc = fbde_pkg::OP_POINT;
    else if (pick < 432) cmd.opc = fbde_pkg::OP_BLIT;
    else if (pick < 532) cmd.opc = fbde_pkg::OP_OUTLINE;
    else if (pick < 682) cmd.opc = fbde_pkg::OP_FILL;
    else if (pick < 970) cmd.opc = fbde_pkg::OP_READ;
    else cmd.opc = $urandom_range(1) ? OP_SPARE_7 : OP_SPARE_6;
    cmd.fx = 1'($urandom_range(1));
    cmd.c  = 24'($urandom_range(24'hFFFFFF));
    cmd.sx = 8'($urandom_range(255));
    cmd.sy = 8'($urandom_range(255));
    cmd.w  = random_extent();
    cmd.h  = random_extent();
    // aim scrolled shapes at the visible window
    aim_x = 0;
    aim_y = 0;
    if (cmd.fx && (cmd.opc == fbde_pkg::OP_BLIT || cmd.opc == fbde_pkg::OP_OUTLINE ||
                   cmd.opc == fbde_pkg::OP_FILL)) begin
      aim_x = scroll_x_set;
      aim_y = scroll_y_set;
    end
    if (cmd.opc == fbde_pkg::OP_BLIT) begin
      aim_x -= int'(cmd.sx);
      aim_y -= int'(cmd.sy);
    end
    cmd.px = random_coord(aim_x);
    cmd.py = random_coord(aim_y);
    // half the reads go back to the last plotted pixel
    if (cmd.opc == fbde_pkg::OP_READ && $urandom_range(1)) begin
      cmd.px = last_x;
      cmd.py = last_y;
    end
    if (cmd.opc == fbde_pkg::OP_POINT) begin
      last_x = cmd.px;
      last_y = cmd.py;
    end else if (cmd.opc == fbde_pkg::OP_BLIT) begin
      last_x = 13'(int'(cmd.px) - (cmd.fx ? scroll_x_set : 0) + int'(cmd.sx));
      last_y = 13'(int'(cmd.py) - (cmd.fx ? scroll_y_set : 0) + int'(cmd.sy));
    end
  endtask

  // present a request and hold it until the block takes it
  task automatic issue_command(input draw_cmd_t cmd);
    operation <= cmd.opc;
    pos_x     <= cmd.px;
    pos_y     <= cmd.py;
    size_w    <= cmd.w;
    size_h    <= cmd.h;
    sub_x     <= cmd.sx;
    sub_y     <= cmd.sy;
    color     <= cmd.c;
    fixed     <= cmd.fx;
    start     <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic sender_gap(input int unsigned pct);
    if (pct != 0 && $urandom_range(99) < pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
  endtask

  // drain the block, then write both scroll registers
  task automatic set_scroll(input int new_x, input int new_y);
    start <= 1'b0;
    do @(negedge clk); while (awaiting != 0 || busy);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= fbde_pkg::REG_SCROLL_X;
    cfg_data  <= 13'(new_x);
    @(posedge clk);
    cfg_index <= fbde_pkg::REG_SCROLL_Y;
    cfg_data  <= 13'(new_y);
    @(posedge clk);
    cfg_write <= 1'b0;
    scroll_x_set = new_x;
    scroll_y_set = new_y;
  endtask

  task automatic run_phase(input int unsigned pct, input int new_x, input int new_y);
    draw_cmd_t cmd;
    set_scroll(new_x, new_y);
    repeat (RANDOM_PER_PHASE) begin
      random_command(cmd);
      issue_command(cmd);
      sender_gap(pct);
    end
  endtask

  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    operation <= '0;
    pos_x     <= '0;
    pos_y     <= '0;
    size_w    <= '0;
    size_h    <= '0;
    sub_x     <= '0;
    sub_y     <= '0;
    color     <= '0;
    fixed     <= 1'b0;
    cfg_write <= 1'b0;
    cfg_index <= fbde_pkg::REG_SCROLL_X;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: whole frame written first so every later read is defined
    directed.push_back(make_cmd(fbde_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 24'hFFFFFF, 1'b1));
    directed.push_back(make_cmd(fbde_pkg::OP_POINT, 0, 0, 0, 0, 0, 0, 24'h000000, 1'b0));
    directed.push_back(make_cmd(fbde_pkg::OP_POINT, 255, 255, 0, 0, 0, 0, 24'hA5C35A, 1'b1));
    directed.push_back(make_cmd(fbde_pkg::OP_POINT, -1, 0, 0, 0, 0, 0, 24'h123456, 1'b0));
    directed.push_back(make_cmd(fbde_pkg::OP_POINT, 0, 256, 0, 0, 0, 0, 24'h654321, 1'b0));
    directed.push_back(make_cmd(fbde_pkg::OP_POINT, -4096, 4095, 0, 0, 0, 0, 24'h00FF00,
                                1'b1));
    directed.push_back(make_cmd(fbde_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 24'hFFFFFF, 1'b0));
    directed.push_back(make_cmd(fbde_pkg::OP_READ, 255, 255, 0, 0, 0, 0, 24'h0, 1'b1));
    directed.push_back(make_cmd(fbde_pkg::OP_READ, 4095, -4096, 0, 0, 0, 0, 24'h0, 1'b0));
    directed.push_back(make_cmd(fbde_pkg::OP_READ, 256, 0, 0, 0, 0, 0, 24'h0, 1'b0));
    directed.push_back(make_cmd(fbde_pkg::OP_BLIT, 10, 20, 0, 0, 0, 0, 24'h0000FF, 1'b1));
    directed.push_back(make_cmd(fbde_pkg::OP_BLIT, 0, 0, 0, 0, 255, 255, 24'h00FFFF, 1'b0));
    directed.push_back(make_cmd(fbde_pkg::OP_BLIT, 0, 0, 0, 0, 0, 0, 24'hFF0000, 1'b1));
    directed.push_back(make_cmd(fbde_pkg::OP_BLIT, -4096, -4096, 0, 0, 255, 255, 24'h777777,
                                1'b1));
    directed.push_back(make_cmd(fbde_pkg::OP_OUTLINE, 2, 2, 5, 3, 0, 0, 24'h3C3C3C, 1'b1));
    directed.push_back(make_cmd(fbde_pkg::OP_OUTLINE, 100, 100, 0, 0, 0, 0, 24'hC0FFEE,
                                1'b0));
    directed.push_back(make_cmd(fbde_pkg::OP_OUTLINE, -10, -10, 4096, 4096, 0, 0, 24'h0F0F0F,
                                1'b0));
    directed.push_back(make_cmd(fbde_pkg::OP_FILL, 50, 50, 0, 5, 0, 0, 24'hABCDEF, 1'b0));
    directed.push_back(make_cmd(fbde_pkg::OP_FILL, 20, 20, 4, 4, 0, 0, 24'h808080, 1'b1));
    directed.push_back(make_cmd(fbde_pkg::OP_FILL, 200, 200, 4096, 4096, 0, 0, 24'h5A5A5A,
                                1'b0));
    directed.push_back(make_cmd(fbde_pkg::OP_READ, 5, 23, 0, 0, 0, 0, 24'h0, 1'b0));
    directed.push_back(make_cmd(fbde_pkg::OP_READ, 100, 100, 0, 0, 0, 0, 24'h0, 1'b1));
    directed.push_back(make_cmd(fbde_pkg::OP_READ, 210, 210, 0, 0, 0, 0, 24'h0, 1'b0));
    directed.push_back(make_cmd(OP_SPARE_6, 3, 3, 1, 1, 1, 1, 24'hFFFFFF, 1'b1));
    directed.push_back(make_cmd(OP_SPARE_7, 3, 3, 1, 1, 1, 1, 24'hFFFFFF, 1'b0));

    set_scroll(5, -3);
    foreach (directed[i]) issue_command(directed[i]);

    // random phases, each under its own scroll setting and a chosen sender pacing
    run_phase(0, -4096, 4095);
    run_phase(78, 4095, -4096);
    run_phase(28, int'($urandom_range(600)) - 300, int'($urandom_range(600)) - 300);
    run_phase(0, 0, 0);

    // drain and let any stray result show up
    start <= 1'b0;
    do @(negedge clk); while (awaiting != 0 || busy);
    repeat (16) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("PASS framebuffer_draw_engine_unit");
    end else begin
      $display("FAIL framebuffer_draw_engine_unit");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/fbde_pkg.sv
rtl/framebuffer_draw_engine_unit.sv
bench/framebuffer_draw_engine_unit_checker.sv
bench/framebuffer_draw_engine_unit_tb.sv
